// ===== rtl/scrolling_text_marquee_defines.svh =====
// Assertion macros for the scrolling text marquee.
// Taken in by the top level; expects a clock named clk and a reset named rst.
`ifndef SCROLLING_TEXT_MARQUEE_DEFINES_SVH
`define SCROLLING_TEXT_MARQUEE_DEFINES_SVH

// checked only outside reset
`define STM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define STM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/stm_pkg.sv =====
// Shared types, constants and the 5x7 column font of the scrolling text marquee.
// No dependencies; used by stm_ctrl, stm_dpath and scrolling_text_marquee.
package stm_pkg;

  localparam int ROWS        = 7;
  localparam int ROW_BITS    = 12;
  localparam int GLYPH_COLS  = 5;
  localparam int FONT_DEPTH  = 59;
  localparam logic [7:0] GLYPH_FIRST = 8'd32;
  localparam logic [7:0] GLYPH_LAST  = 8'd90;
  localparam logic [7:0] LOWER_A     = 8'd97;
  localparam logic [7:0] LOWER_Z     = 8'd122;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CLEAR = 4'b0010,
    S_PUSH  = 4'b0100,
    S_TAIL  = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_GLYPH = 2'd1,
    OP_BLANK = 2'd2
  } op_t;

  typedef struct packed {
    logic       load_char;
    logic       step;
    op_t        op;
    logic [2:0] col;
    logic       last_frame;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } sts_t;

  // columns 0..4 packed left to right, one byte each
  localparam logic [39:0] FONT [FONT_DEPTH] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h3636000000, 40'h5636000000,
    40'h0814224100, 40'h2424242424, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543
  };

  // pixel column for an upper-cased code; blank outside the font range
  function automatic logic [6:0] glyph_column(logic [7:0] code, logic [2:0] col);
    logic [39:0] entry;
    logic [6:0]  bits;
    entry = '0;
    bits  = '0;
    if (code >= GLYPH_FIRST && code <= GLYPH_LAST) begin
      entry = FONT[6'(code - GLYPH_FIRST)];
    end
    case (col)
      3'd0:    bits = entry[38:32];
      3'd1:    bits = entry[30:24];
      3'd2:    bits = entry[22:16];
      3'd3:    bits = entry[14:8];
      3'd4:    bits = entry[6:0];
      default: bits = '0;
    endcase
    return bits;
  endfunction

endpackage

// ===== rtl/scrolling_text_marquee.sv =====
// Scrolling text marquee for a 7-row LED matrix DISPLAY_COLUMNS wide.
// Input channel (in_valid/in_ready): one word per character, with message_end
// marking the last one. Lower case folds to upper; codes outside 32..90 are blank.
// Output channel (out_valid/out_ready): one frame word per column shift, seven
// 12-bit rows (bit 11 leftmost) plus frame_final on the last frame of a message.
// A character gives 6 frames, the first of a message one blank frame more, and
// the last of a message DISPLAY_COLUMNS-1 trailing blank frames.
// The window register gives one frame per cycle while the receiver takes them;
// in_ready is high only while the sequencer is idle, and the next character
// is taken while the last frame waits.
// A stalled receiver holds the frame register and the sequencer waits on it.
// Reset (rst, synchronous) clears the window, ends any message and empties
// the frame register.
// Depends on stm_pkg, stm_ctrl, stm_dpath and scrolling_text_marquee_defines.svh.
`include "scrolling_text_marquee_defines.svh"

module scrolling_text_marquee import stm_pkg::*; #(
  parameter int DISPLAY_COLUMNS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          character,
  input  logic                message_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ROW_BITS-1:0] row_one,
  output logic [ROW_BITS-1:0] row_two,
  output logic [ROW_BITS-1:0] row_three,
  output logic [ROW_BITS-1:0] row_four,
  output logic [ROW_BITS-1:0] row_five,
  output logic [ROW_BITS-1:0] row_six,
  output logic [ROW_BITS-1:0] row_seven,
  output logic                frame_final
);

  cmd_t                cmd;
  sts_t                sts;
  logic [ROW_BITS-1:0] rows [ROWS];

  stm_ctrl #(
    .DISPLAY_COLUMNS(DISPLAY_COLUMNS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .message_end(message_end),
    .sts        (sts),
    .cmd        (cmd)
  );

  stm_dpath #(
    .DISPLAY_COLUMNS(DISPLAY_COLUMNS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .character  (character),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .rows       (rows),
    .frame_final(frame_final)
  );

  assign row_one   = rows[0];
  assign row_two   = rows[1];
  assign row_three = rows[2];
  assign row_four  = rows[3];
  assign row_five  = rows[4];
  assign row_six   = rows[5];
  assign row_seven = rows[6];

  `STM_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "took a word while busy")
  `STM_ASSERT(a_no_step_idle, in_ready |-> !cmd.step, "frame produced while idle")
  `STM_ASSERT(a_no_overwrite, (out_valid && !out_ready) |-> !cmd.step, "pending frame overwritten")
  `STM_ASSERT_ALWAYS(a_empty_after_rst, rst |=> !out_valid, "frame valid after reset")

endmodule

// ===== rtl/stm_ctrl.sv =====
// Sequencer of the marquee: takes characters and steps the window one column per frame.
// Depends on stm_pkg; drives stm_dpath through cmd_t and reads sts_t back.
module stm_ctrl import stm_pkg::*; #(
  parameter int DISPLAY_COLUMNS = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic message_end,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int CNT_W = $clog2(DISPLAY_COLUMNS);
  localparam logic [CNT_W-1:0] GAP_COL  = CNT_W'(GLYPH_COLS);
  localparam logic [CNT_W-1:0] TAIL_END = CNT_W'(DISPLAY_COLUMNS - 2);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             last, last_next;
  logic             in_message, in_message_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      last       <= 1'b0;
      in_message <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      last       <= last_next;
      in_message <= in_message_next;
    end
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    last_next       = last;
    in_message_next = in_message;
    in_ready        = (state == S_IDLE);
    cmd             = '0;
    cmd.op          = OP_BLANK;
    cmd.col         = cnt[2:0];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_char = 1'b1;
          last_next     = message_end;
          cnt_next      = '0;
          state_next    = in_message ? S_PUSH : S_CLEAR;
        end
      end
      S_CLEAR: begin
        if (sts.slot_free) begin
          cmd.step        = 1'b1;
          cmd.op          = OP_CLEAR;
          in_message_next = 1'b1;
          state_next      = S_PUSH;
        end
      end
      S_PUSH: begin
        if (sts.slot_free) begin
          cmd.step = 1'b1;
          if (cnt == GAP_COL) begin
            cmd.op     = OP_BLANK;
            cnt_next   = '0;
            state_next = last ? S_TAIL : S_IDLE;
          end else begin
            cmd.op   = OP_GLYPH;
            cnt_next = cnt + 1'b1;
          end
        end
      end
      S_TAIL: begin
        if (sts.slot_free) begin
          cmd.step = 1'b1;
          cmd.op   = OP_BLANK;
          if (cnt == TAIL_END) begin
            cmd.last_frame  = 1'b1;
            in_message_next = 1'b0;
            cnt_next        = '0;
            state_next      = S_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/stm_dpath.sv =====
// Datapath of the marquee: character register, font lookup, pixel window, frame register.
// Depends on stm_pkg; commanded by stm_ctrl.
module stm_dpath import stm_pkg::*; #(
  parameter int DISPLAY_COLUMNS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          character,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [ROW_BITS-1:0] rows [ROWS],
  output logic                frame_final
);

  localparam int SHOW = (DISPLAY_COLUMNS < ROW_BITS) ? DISPLAY_COLUMNS : ROW_BITS;

  logic [7:0]                 code;
  logic [7:0]                 code_next;
  logic [6:0]                 column;
  logic [DISPLAY_COLUMNS-1:0] win      [ROWS];
  logic [DISPLAY_COLUMNS-1:0] win_next [ROWS];

  always_comb begin
    code_next = character;
    if (character inside {[LOWER_A:LOWER_Z]}) begin
      code_next = character - CASE_OFFSET;
    end
  end

  always_comb begin
    column = '0;
    if (cmd.op == OP_GLYPH) begin
      column = glyph_column(code, cmd.col);
    end
  end

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      if (cmd.op == OP_CLEAR) begin
        win_next[r] = '0;
      end else begin
        win_next[r] = {win[r][DISPLAY_COLUMNS-2:0], column[r]};
      end
    end
  end

  assign sts.slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      code <= code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        win[r] <= '0;
      end
    end else if (cmd.step) begin
      for (int r = 0; r < ROWS; r++) begin
        win[r] <= win_next[r];
      end
    end
  end

  // frame register: new window shown in the same edge it is stored
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      for (int r = 0; r < ROWS; r++) begin
        rows[r] <= ROW_BITS'(win_next[r][SHOW-1:0]);
      end
      frame_final <= cmd.last_frame;
    end
  end

endmodule

// ===== bench/marquee_frame_checker.sv =====
// Frame checker for the scrolling text marquee: watches both channels, predicts
// the frames of each accepted character word and compares them in order.
// Depends on stm_pkg for the row count and row width.
module marquee_frame_checker import stm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [7:0]          character,
  input  logic                message_end,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [ROW_BITS-1:0] row_one,
  input  logic [ROW_BITS-1:0] row_two,
  input  logic [ROW_BITS-1:0] row_three,
  input  logic [ROW_BITS-1:0] row_four,
  input  logic [ROW_BITS-1:0] row_five,
  input  logic [ROW_BITS-1:0] row_six,
  input  logic [ROW_BITS-1:0] row_seven,
  input  logic                frame_final,
  output int                  mismatch_count,
  output int                  frames_pending
);

  localparam int COLUMNS       = 12;
  localparam int COLS_PER_CHAR = 6;

  typedef struct packed {
    logic [ROWS-1:0][ROW_BITS-1:0] rows;
    logic                          last_frame;
  } frame_t;

  // one byte per column, column 0 in the top byte; bit 0 of a byte is row one
  localparam logic [39:0] CHAR_FONT [59] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h3636000000, 40'h5636000000,
    40'h0814224100, 40'h2424242424, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543
  };

  logic [COLUMNS-1:0] window [ROWS];
  logic               in_message;
  frame_t             expected_frames [$];

  function automatic logic [6:0] font_column(logic [7:0] code, int col);
    logic [39:0] entry;
    entry = '0;
    if (code >= 8'd32 && code <= 8'd90) entry = CHAR_FONT[6'(code - 8'd32)];
    return 7'(entry[39 - 8*col -: 8]);
  endfunction

  task automatic queue_frame(input logic is_last);
    frame_t f;
    for (int r = 0; r < ROWS; r++) f.rows[r] = ROW_BITS'(window[r]);
    f.last_frame = is_last;
    expected_frames.push_back(f);
  endtask

  task automatic shift_column(input logic [6:0] bits);
    for (int r = 0; r < ROWS; r++) window[r] = {window[r][COLUMNS-2:0], bits[r]};
  endtask

  task automatic scroll_character(input logic [7:0] code_in, input logic closes);
    logic [7:0] code;
    code = code_in;
    if (code >= 8'd97 && code <= 8'd122) code = code - 8'd32;
    if (!in_message) begin
      for (int r = 0; r < ROWS; r++) window[r] = '0;
      queue_frame(1'b0);
      in_message = 1'b1;
    end
    for (int c = 0; c < COLS_PER_CHAR; c++) begin
      shift_column(c < 5 ? font_column(code, c) : 7'd0);
      queue_frame(1'b0);
    end
    // blank tail scrolls the message off; only its last frame is marked
    if (closes) begin
      for (int c = 0; c < COLUMNS - 1; c++) begin
        shift_column(7'd0);
        queue_frame(c == COLUMNS - 2);
      end
      in_message = 1'b0;
    end
  endtask

  task automatic compare_frame(input frame_t seen);
    frame_t want;
    if (expected_frames.size() == 0) begin
      $display("%0t: unexpected frame, rows %p final %0b", $realtime, seen.rows,
               seen.last_frame);
      mismatch_count++;
    end else begin
      want = expected_frames.pop_front();
      for (int r = 0; r < ROWS; r++)
        if (seen.rows[r] !== want.rows[r]) begin
          $display("%0t: row %0d expected %03h actual %03h", $realtime, r + 1,
                   want.rows[r], seen.rows[r]);
          mismatch_count++;
        end
      if (seen.last_frame !== want.last_frame) begin
        $display("%0t: frame_final expected %0b actual %0b", $realtime,
                 want.last_frame, seen.last_frame);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    frame_t seen;
    if (rst) begin
      for (int r = 0; r < ROWS; r++) window[r] = '0;
      in_message = 1'b0;
      expected_frames.delete();
      mismatch_count = 0;
      frames_pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen.rows = {row_seven, row_six, row_five, row_four, row_three, row_two,
                     row_one};
        seen.last_frame = frame_final;
        compare_frame(seen);
      end
      if (in_valid && in_ready) scroll_character(character, message_end);
      frames_pending = expected_frames.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the scrolling text marquee bench: clock, reset, character stimulus,
// receiver stalls and the verdict. Depends on stm_pkg, the marquee RTL and
// marquee_frame_checker.
module testbench import stm_pkg::*; ();

  localparam int RANDOM_ITEMS = 350;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int LONG_HOLD    = 300;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          character = '0;
  logic                message_end = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ROW_BITS-1:0] row_one, row_two, row_three, row_four;
  logic [ROW_BITS-1:0] row_five, row_six, row_seven;
  logic                frame_final;
  int                  mismatch_count;
  int                  frames_pending;

  int send_idle_pct = 37;
  int recv_idle_pct = 74;
  bit stall_req     = 1'b0;
  bit stall_done    = 1'b0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int items_sent    = 0;

  scrolling_text_marquee u_dut (
    .clk, .rst, .in_valid, .in_ready, .character, .message_end,
    .out_valid, .out_ready, .row_one, .row_two, .row_three, .row_four,
    .row_five, .row_six, .row_seven, .frame_final
  );

  marquee_frame_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .character, .message_end,
    .out_valid, .out_ready, .row_one, .row_two, .row_three, .row_four,
    .row_five, .row_six, .row_seven, .frame_final, .mismatch_count,
    .frames_pending
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (stall_req && !stall_done) begin
      hold_left  = LONG_HOLD;
      stall_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic [7:0] code, input logic closes);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    character   <= code;
    message_end <= closes;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_code();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return 8'($urandom_range(65, 90));
    if (sel < 60) return 8'($urandom_range(97, 122));
    if (sel < 80) return 8'($urandom_range(32, 64));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic set_phase();
    int phase;
    phase = items_sent * 3 / RANDOM_ITEMS;
    if (phase == 0) begin
      send_idle_pct = 37;
      recv_idle_pct = 74;
    end else if (phase == 1) begin
      send_idle_pct = 74;
      recv_idle_pct = 37;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  initial begin
    int msg_len;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: font edges, case folding, blank codes, one-word messages
    send_word(8'd0, 1'b1);
    send_word(8'd255, 1'b1);
    send_word(8'd32, 1'b0);
    send_word(8'd90, 1'b0);
    send_word(8'd65, 1'b0);
    send_word(8'd97, 1'b0);
    send_word(8'd122, 1'b1);
    send_word(8'd31, 1'b0);
    send_word(8'd91, 1'b0);
    send_word(8'd96, 1'b0);
    send_word(8'd123, 1'b0);
    send_word(8'd127, 1'b0);
    send_word(8'd128, 1'b1);
    send_word(8'd33, 1'b0);
    send_word(8'd87, 1'b0);
    send_word(8'd64, 1'b1);
    send_word(8'd77, 1'b1);
    send_word(8'd170, 1'b0);
    send_word(8'd85, 1'b1);

    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= 40) stall_req = 1'b1;
      if ($urandom_range(0, 99) < 15) begin
        // loose word with a random end flag
        set_phase();
        send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        items_sent++;
      end else begin
        msg_len = $urandom_range(1, 8);
        for (int i = 0; i < msg_len; i++) begin
          set_phase();
          send_word(pick_code(), i == msg_len - 1);
          items_sent++;
        end
      end
    end
    in_valid <= 1'b0;

    while (frames_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
